/* hdl/omft_pkg.sv */
// ----------------------------------------------------------------------------
// omft_pkg: shared types for the OOK remote-socket frame transmitter
// Item and result records, duration width and the sizing defaults.
// ----------------------------------------------------------------------------
package omft_pkg;

  localparam int unsigned MsgW              = 32;
  localparam int unsigned DurW              = 16;
  localparam int unsigned MessageBitsDefault = 32;
  localparam int unsigned QueueDepthDefault  = 2;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } op_e;

  // register index, byte address is 4 * index
  typedef enum logic [2:0] {
    REG_PROTOCOL_ENABLE = 3'd0,
    REG_INVERT_OUTPUT   = 3'd1,
    REG_MARKER_HIGH     = 3'd2,
    REG_FIRST_GAP       = 3'd3,
    REG_SECOND_GAP      = 3'd4,
    REG_PULSE_HIGH      = 3'd5,
    REG_LONG_LOW        = 3'd6,
    REG_SHORT_LOW       = 3'd7
  } reg_e;

  typedef struct packed {
    op_e             kind;
    logic [MsgW-1:0] message;
  } item_t;

  typedef struct packed {
    logic            protocol_enable;
    logic            invert_output;
    logic [DurW-1:0] marker_high_ticks;
    logic [DurW-1:0] first_gap_ticks;
    logic [DurW-1:0] second_gap_ticks;
    logic [DurW-1:0] pulse_high_ticks;
    logic [DurW-1:0] long_low_ticks;
    logic [DurW-1:0] short_low_ticks;
  } cfg_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic frame_done;
    logic start_rejected;
  } res_t;

endpackage

/* hdl/omft_front.sv */
// ----------------------------------------------------------------------------
// omft_front: input stage
// Registers each incoming transaction, decodes the operation and hands the
// item on to the queue.
// ----------------------------------------------------------------------------
module omft_front
  import omft_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            operation_i,
  input  logic [MsgW-1:0] message_i,
  output logic            push_o,
  output item_t           item_o,
  input  logic            q_full_i
);

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  accept;

  assign push_o     = valid_q && !q_full_i;
  assign in_stall_o = valid_q && q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign item_o     = item_q;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (accept) begin
      valid_d      = 1'b1;
      item_d.kind  = operation_i ? OP_START : OP_TICK;
      item_d.message = message_i;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

endmodule

/* hdl/omft_queue.sv */
// ----------------------------------------------------------------------------
// omft_queue: item queue
// Small FIFO between the input stage and the frame engine.
// ----------------------------------------------------------------------------
module omft_queue
  import omft_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    if (p == PtrW'(Depth - 1)) begin
      return '0;
    end
    return p + PtrW'(1);
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count exceeds depth");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

endmodule

/* hdl/omft_back.sv */
// ----------------------------------------------------------------------------
// omft_back: frame engine
// Steps the frame sequencer once per item taken from the queue and holds
// the result in the output register.
// ----------------------------------------------------------------------------
module omft_back
  import omft_pkg::*;
#(
  parameter int unsigned MESSAGE_BITS = MessageBitsDefault
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  head_valid_i,
  input  item_t head_i,
  output logic  pop_o,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  output res_t  res_o
);

  localparam int unsigned CntW = $clog2(MESSAGE_BITS + 1);

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_MARK1   = 3'd1,
    PH_GAP1    = 3'd2,
    PH_MARK2   = 3'd3,
    PH_GAP2    = 3'd4,
    PH_SYMHI   = 3'd5,
    PH_SYMLO   = 3'd6,
    PH_ENDMARK = 3'd7
  } phase_e;

  phase_e                  phase_q, phase_d, ph;
  logic [DurW-1:0]         count_q, count_d, cnt;
  logic [MESSAGE_BITS-1:0] shift_q, shift_d, sh;
  logic [CntW-1:0]         bitcnt_q, bitcnt_d, bc;
  logic                    half_q, half_d, hf;
  logic                    out_valid_q, out_valid_d;
  res_t                    res_q, res_d, res;
  logic                    start_ok;
  logic [CntW:0]           bc_next;

  // a zero duration behaves as one tick
  function automatic logic [DurW-1:0] dur(input logic [DurW-1:0] v);
    return (v == '0) ? DurW'(1) : v;
  endfunction

  assign pop_o       = head_valid_i && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  always_comb begin
    ph  = phase_q;
    cnt = count_q;
    sh  = shift_q;
    bc  = bitcnt_q;
    hf  = half_q;
    res = '0;

    start_ok           = (head_i.kind == OP_START) && (phase_q == PH_IDLE) &&
                         cfg_i.protocol_enable;
    res.start_rejected = (head_i.kind == OP_START) && !start_ok;
    bc_next            = (CntW + 1)'(bitcnt_q) + (CntW + 1)'(1);

    if (start_ok) begin
      sh  = MESSAGE_BITS'(head_i.message);
      bc  = '0;
      hf  = 1'b0;
      ph  = PH_MARK1;
      cnt = dur(cfg_i.marker_high_ticks);
    end

    res.busy_res = (ph != PH_IDLE);
    unique case (ph) inside
      PH_MARK1, PH_MARK2, PH_SYMHI, PH_ENDMARK: res.line_level = 1'b1;
      default:                                  res.line_level = 1'b0;
    endcase

    if (ph != PH_IDLE) begin
      cnt = cnt - DurW'(1);
      if (cnt == '0) begin
        unique case (ph)
          PH_MARK1: begin
            ph  = PH_GAP1;
            cnt = dur(cfg_i.first_gap_ticks);
          end
          PH_GAP1: begin
            ph  = PH_MARK2;
            cnt = dur(cfg_i.marker_high_ticks);
          end
          PH_MARK2: begin
            ph  = PH_GAP2;
            cnt = dur(cfg_i.second_gap_ticks);
          end
          PH_GAP2: begin
            hf  = 1'b0;
            bc  = '0;
            ph  = PH_SYMHI;
            cnt = dur(cfg_i.pulse_high_ticks);
          end
          PH_SYMHI: begin
            // long gap when the bit differs from the symbol half
            ph  = PH_SYMLO;
            cnt = (sh[MESSAGE_BITS-1] ^ hf) ? dur(cfg_i.long_low_ticks)
                                            : dur(cfg_i.short_low_ticks);
          end
          PH_SYMLO: begin
            if (!hf) begin
              hf  = 1'b1;
              ph  = PH_SYMHI;
              cnt = dur(cfg_i.pulse_high_ticks);
            end else begin
              hf = 1'b0;
              if (bc_next >= (CntW + 1)'(MESSAGE_BITS)) begin
                ph  = PH_ENDMARK;
                cnt = dur(cfg_i.marker_high_ticks);
              end else begin
                bc  = bc_next[CntW-1:0];
                sh  = sh << 1;
                ph  = PH_SYMHI;
                cnt = dur(cfg_i.pulse_high_ticks);
              end
            end
          end
          PH_ENDMARK: begin
            ph             = PH_IDLE;
            cnt            = '0;
            res.frame_done = 1'b1;
          end
          default: begin
            ph  = PH_IDLE;
            cnt = '0;
          end
        endcase
      end
    end

    res.line_level = res.line_level ^ cfg_i.invert_output;

    phase_d     = phase_q;
    count_d     = count_q;
    shift_d     = shift_q;
    bitcnt_d    = bitcnt_q;
    half_d      = half_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (pop_o) begin
      phase_d     = ph;
      count_d     = cnt;
      shift_d     = sh;
      bitcnt_d    = bc;
      half_d      = hf;
      res_d       = res;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      count_q     <= '0;
      shift_q     <= '0;
      bitcnt_q    <= '0;
      half_q      <= 1'b0;
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      phase_q     <= phase_d;
      count_q     <= count_d;
      shift_q     <= shift_d;
      bitcnt_q    <= bitcnt_d;
      half_q      <= half_d;
      out_valid_q <= out_valid_d;
      res_q       <= res_d;
    end
  end

  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && res.frame_done) |=> (phase_q == PH_IDLE))
    else $error("frame end did not return to idle");

  a_reject_only_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.start_rejected |-> (head_i.kind == OP_START))
    else $error("tick flagged as rejected start");

  a_bitcnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CntW + 1)'(bitcnt_q) < (CntW + 1)'(MESSAGE_BITS))
    else $error("bit counter beyond message length");

  a_count_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_IDLE) |-> (count_q != '0))
    else $error("segment counter empty while sending");

endmodule

/* hdl/ook_manchester_frame_transmitter.sv */
// ----------------------------------------------------------------------------
// ook_manchester_frame_transmitter: OOK remote-socket frame transmitter
// Drives one line level per microsecond tick for a preamble, Manchester-
// style data symbols and an end marker, with APB-style timing registers.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o): one transaction per tick.
//   operation_i = 0 is a plain tick, 1 starts a frame with message_i (the
//   start transaction is itself the first tick of the first marker).
//   Output channel (out_valid_o / out_stall_i): exactly one result per input
//   transaction, in order: line level, busy, frame done, start rejected.
//   Throughput: one transaction per cycle while the output is not stalled.
//   Path: each transaction passes the input register and the queue write, and
//   the frame engine registers the result as it pops.
//   A stalled output holds its result; the queue then fills and in_stall_o
//   rises, so nothing is dropped.
//   Reset: idle, line logically low, invert on (idle results show the line
//   high), protocol enabled, timing registers at their defaults. The user
//   must write registers only while no transaction is in flight; the block
//   itself does not enforce this. A new duration applies from the next segment.
// ----------------------------------------------------------------------------
module ook_manchester_frame_transmitter
  import omft_pkg::*;
#(
  parameter int unsigned MESSAGE_BITS = MessageBitsDefault,
  parameter int unsigned QUEUE_DEPTH  = QueueDepthDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            operation_i,
  input  logic [MsgW-1:0] message_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            line_level_o,
  output logic            busy_res_o,
  output logic            frame_done_o,
  output logic            start_rejected_o,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [4:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  localparam cfg_t CfgReset = '{
    protocol_enable:   1'b1,
    invert_output:     1'b1,
    marker_high_ticks: 16'd275,
    first_gap_ticks:   16'd9900,
    second_gap_ticks:  16'd2675,
    pulse_high_ticks:  16'd310,
    long_low_ticks:    16'd1340,
    short_low_ticks:   16'd310
  };

  cfg_t  cfg_q, cfg_d;
  reg_e  reg_sel;
  logic  wr_en;
  logic  push, q_full, pop, head_valid;
  item_t front_item, head_item;
  res_t  res;

  assign pready  = 1'b1;
  assign reg_sel = reg_e'(paddr[4:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_sel)
        REG_PROTOCOL_ENABLE: cfg_d.protocol_enable   = pwdata[0];
        REG_INVERT_OUTPUT:   cfg_d.invert_output     = pwdata[0];
        REG_MARKER_HIGH:     cfg_d.marker_high_ticks = pwdata[DurW-1:0];
        REG_FIRST_GAP:       cfg_d.first_gap_ticks   = pwdata[DurW-1:0];
        REG_SECOND_GAP:      cfg_d.second_gap_ticks  = pwdata[DurW-1:0];
        REG_PULSE_HIGH:      cfg_d.pulse_high_ticks  = pwdata[DurW-1:0];
        REG_LONG_LOW:        cfg_d.long_low_ticks    = pwdata[DurW-1:0];
        REG_SHORT_LOW:       cfg_d.short_low_ticks   = pwdata[DurW-1:0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_PROTOCOL_ENABLE: prdata = 32'(cfg_q.protocol_enable);
      REG_INVERT_OUTPUT:   prdata = 32'(cfg_q.invert_output);
      REG_MARKER_HIGH:     prdata = 32'(cfg_q.marker_high_ticks);
      REG_FIRST_GAP:       prdata = 32'(cfg_q.first_gap_ticks);
      REG_SECOND_GAP:      prdata = 32'(cfg_q.second_gap_ticks);
      REG_PULSE_HIGH:      prdata = 32'(cfg_q.pulse_high_ticks);
      REG_LONG_LOW:        prdata = 32'(cfg_q.long_low_ticks);
      REG_SHORT_LOW:       prdata = 32'(cfg_q.short_low_ticks);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  omft_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .message_i   (message_i),
    .push_o      (push),
    .item_o      (front_item),
    .q_full_i    (q_full)
  );

  omft_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .item_o  (head_item)
  );

  omft_back #(
    .MESSAGE_BITS (MESSAGE_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (head_valid),
    .head_i       (head_item),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .res_o        (res)
  );

  assign line_level_o     = res.line_level;
  assign busy_res_o       = res.busy_res;
  assign frame_done_o     = res.frame_done;
  assign start_rejected_o = res.start_rejected;

endmodule
